@@ design/maxrects_bssf_packer_assert.svh @@
// Assertion macros shared by the packer RTL.
// Every macro samples on the rising edge of clock and is off while reset is high.
`ifndef MAXRECTS_BSSF_PACKER_ASSERT_SVH
`define MAXRECTS_BSSF_PACKER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MRP_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("packer assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MRP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("packer assertion failed");

`endif

@@ design/mrp_pkg.sv @@
package mrp_pkg;

   // Default sizes of the free-rectangle store and of one coordinate.
   localparam int MAX_FREE_DEF   = 256;
   localparam int COORD_BITS_DEF = 15;

   // Fixed field widths.
   localparam int SPRITE_W = 15;
   localparam int FOOT_W   = 17;
   localparam int PAD_W    = 8;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 15;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_ATLAS_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ATLAS_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BORDER       = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PADDING      = 2'd3;

   // Request actions.
   localparam logic ACT_CLEAR = 1'b0;
   localparam logic ACT_PLACE = 1'b1;

   // Result status codes.
   typedef enum logic [1:0] {
      STAT_PLACED  = 2'd0,
      STAT_NO_FIT  = 2'd1,
      STAT_CLEARED = 2'd2,
      STAT_DROPPED = 2'd3
   } status_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_SCAN_RD,
      ST_SCAN_EV,
      ST_CARVE_RD,
      ST_CARVE_EV,
      ST_CARVE_PC,
      ST_COPY_RD,
      ST_COPY_WR,
      ST_PRUNE_RDI,
      ST_PRUNE_LDI,
      ST_PRUNE_J,
      ST_PRUNE_CHK,
      ST_RESP
   } state_type;

   // Flags from the split unit.
   typedef struct packed {
      logic       overlap;
      logic [3:0] piece_vld;
   } split_flags_type;

endpackage

@@ design/mrp_split.sv @@
module mrp_split import mrp_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic [4*COORD_BITS-1:0]       free_rect,
   input  logic [COORD_BITS-1:0]         foot_l,
   input  logic [COORD_BITS-1:0]         foot_t,
   input  logic [COORD_BITS-1:0]         foot_r,
   input  logic [COORD_BITS-1:0]         foot_b,
   output split_flags_type               flags,
   output logic [3:0][4*COORD_BITS-1:0]  pieces
);

   localparam int CB = COORD_BITS;

   logic [CB-1:0] f_l, f_t, f_r, f_b;

   // Unpack the free rectangle as left, top, right, bottom.
   assign f_l = free_rect[4*CB-1 -: CB];
   assign f_t = free_rect[3*CB-1 -: CB];
   assign f_r = free_rect[2*CB-1 -: CB];
   assign f_b = free_rect[CB-1 -: CB];

   // Strict overlap between the footprint and the free rectangle.
   assign flags.overlap = (foot_l < f_r) && (foot_r > f_l) && (foot_t < f_b) && (foot_b > f_t);

   // The four maximal pieces left, right, above and below the footprint.
   assign flags.piece_vld[0] = foot_l > f_l;
   assign flags.piece_vld[1] = foot_r < f_r;
   assign flags.piece_vld[2] = foot_t > f_t;
   assign flags.piece_vld[3] = foot_b < f_b;

   assign pieces[0] = {f_l, f_t, foot_l, f_b};
   assign pieces[1] = {foot_r, f_t, f_r, f_b};
   assign pieces[2] = {f_l, f_t, f_r, foot_t};
   assign pieces[3] = {f_l, foot_b, f_r, f_b};

endmodule

@@ design/maxrects_bssf_packer.sv @@
// Channel   | Ports                                               | Handshake
// ----------+-----------------------------------------------------+-------------------------
// request   | req_action, req_sprite_width, req_sprite_height     | start high, busy low
// result    | rsp_status, rsp_pos_x, rsp_pos_y                    | rsp_valid, one cycle
// config    | csr_index, csr_wdata                                | csr_valid and csr_ready
//
// A clear request writes the seed, then raises the result strobe in the cycle after that.
// A place request scans the free rectangles, splits them, writes each new piece to the buffer,
// appends the pieces to the store and prunes it by comparing pairs of entries, so the time
// grows with the square of the store fill; the single memory read port sets it.
// Reset is synchronous and empties the store at once; no clearing pass is needed.
// The receiver cannot stall: each result is shown for exactly one cycle.
`include "maxrects_bssf_packer_assert.svh"

module maxrects_bssf_packer import mrp_pkg::*; #(
   parameter int MAX_FREE   = MAX_FREE_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_action,
   input  logic [SPRITE_W-1:0]  req_sprite_width,
   input  logic [SPRITE_W-1:0]  req_sprite_height,
   output logic                 rsp_valid,
   output logic [1:0]           rsp_status,
   output logic [SPRITE_W-1:0]  rsp_pos_x,
   output logic [SPRITE_W-1:0]  rsp_pos_y,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata
);

   localparam int CB  = COORD_BITS;
   localparam int RW  = 4 * CB;
   localparam int CW  = $clog2(MAX_FREE + 1);
   localparam int AW  = $clog2(MAX_FREE);
   localparam int SW  = $clog2(4 * MAX_FREE + 1);
   localparam int SAW = $clog2(4 * MAX_FREE);
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_FREE);

   // Memories: the free-rectangle store and the piece buffer.
   logic [RW-1:0] free_mem  [MAX_FREE];
   logic [RW-1:0] spare_mem [4*MAX_FREE];

   state_type state_ff, state_in;

   logic [14:0]        aw_ff, ah_ff;
   logic [PAD_W-1:0]   border_ff, pad_ff;

   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [CW-1:0]      keep_ff, keep_in;
   logic [CW-1:0]      j_ff, j_in;
   logic [SW-1:0]      npc_ff, npc_in;
   logic [SW-1:0]      sidx_ff, sidx_in;
   logic [FOOT_W-1:0]  fw_ff, fw_in, fh_ff, fh_in;
   logic               found_ff, found_in;
   logic               dropped_ff, dropped_in;
   logic [CB-1:0]      best_s_ff, best_s_in, best_l_ff, best_l_in;
   logic [CB-1:0]      ul_ff, ul_in, ut_ff, ut_in, ur_ff, ur_in, ub_ff, ub_in;
   logic [3:0]         pvld_ff, pvld_in;
   logic [3:0][RW-1:0] piece_ff, piece_in;
   logic [RW-1:0]      cur_ff, cur_in;
   status_type         status_ff, status_in;

   logic [RW-1:0]      free_rd_ff, spare_rd_ff;

   // Memory port controls.
   logic               free_re, free_we, spare_re, spare_we;
   logic [AW-1:0]      free_raddr, free_waddr;
   logic [RW-1:0]      free_wdata;
   logic [SAW-1:0]     spare_raddr, spare_waddr;
   logic [RW-1:0]      spare_wdata;

   // Shared datapath terms.
   logic [CB-1:0]      f_l, f_t, f_r, f_b, c_l, c_t, c_r, c_b;
   logic [CB-1:0]      rw, rh, dx, dy, s_val, l_val;
   logic               fits, better, last_entry;
   logic [CW-1:0]      idx_inc, jn;
   logic               j_done, contained, seed_ok;
   logic [3:0]         pc_one;
   logic [RW-1:0]      pc_sel;
   logic               pc_last;
   split_flags_type    sflags;
   logic [3:0][RW-1:0] spieces;

   assign f_l = free_rd_ff[RW-1 -: CB];
   assign f_t = free_rd_ff[3*CB-1 -: CB];
   assign f_r = free_rd_ff[2*CB-1 -: CB];
   assign f_b = free_rd_ff[CB-1 -: CB];
   assign c_l = cur_ff[RW-1 -: CB];
   assign c_t = cur_ff[3*CB-1 -: CB];
   assign c_r = cur_ff[2*CB-1 -: CB];
   assign c_b = cur_ff[CB-1 -: CB];

   // Fit score of the rectangle just read: short and long leftover edge.
   assign rw     = (f_r >= f_l) ? f_r - f_l : '0;
   assign rh     = (f_b >= f_t) ? f_b - f_t : '0;
   assign fits   = (FOOT_W'(rw) >= fw_ff) && (FOOT_W'(rh) >= fh_ff);
   assign dx     = rw - CB'(fw_ff);
   assign dy     = rh - CB'(fh_ff);
   assign s_val  = (dx < dy) ? dx : dy;
   assign l_val  = (dx < dy) ? dy : dx;
   assign better = fits && (!found_ff || (s_val < best_s_ff) ||
                            ((s_val == best_s_ff) && (l_val < best_l_ff)));

   assign idx_inc    = idx_ff + CW'(1);
   assign last_entry = idx_inc == count_ff;

   // Pruning compares against earlier survivors and later entries only.
   assign jn        = ((j_ff >= keep_ff) && (j_ff <= idx_ff)) ? idx_inc : j_ff;
   assign j_done    = jn >= count_ff;
   assign contained = (c_l >= f_l) && (c_t >= f_t) && (c_r <= f_r) && (c_b <= f_b);

   // Seed condition for a clear.
   assign seed_ok = (aw_ff > {6'd0, border_ff, 1'b0}) && (ah_ff > {6'd0, border_ff, 1'b0});

   // Lowest pending piece.
   assign pc_one  = pvld_ff & (~pvld_ff + 4'd1);
   assign pc_last = (pvld_ff & ~pc_one) == 4'd0;
   always_comb begin
      pc_sel = piece_ff[3];
      case (pc_one)
         4'b0001: pc_sel = piece_ff[0];
         4'b0010: pc_sel = piece_ff[1];
         4'b0100: pc_sel = piece_ff[2];
         default: pc_sel = piece_ff[3];
      endcase
   end

   mrp_split #(
      .COORD_BITS (COORD_BITS)
   ) u_split (
      .free_rect (free_rd_ff),
      .foot_l    (ul_ff),
      .foot_t    (ut_ff),
      .foot_r    (ur_ff),
      .foot_b    (ub_ff),
      .flags     (sflags),
      .pieces    (spieces)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_action == ACT_CLEAR) state_in = ST_CLEAR;
               else if (count_ff == '0)     state_in = ST_RESP;
               else                         state_in = ST_SCAN_RD;
            end
         end
         ST_CLEAR:    state_in = ST_RESP;
         ST_SCAN_RD:  state_in = ST_SCAN_EV;
         ST_SCAN_EV: begin
            if (!last_entry)                state_in = ST_SCAN_RD;
            else if (found_ff || better)    state_in = ST_CARVE_RD;
            else                            state_in = ST_RESP;
         end
         ST_CARVE_RD: state_in = ST_CARVE_EV;
         ST_CARVE_EV: begin
            if (sflags.overlap && (sflags.piece_vld != 4'd0)) state_in = ST_CARVE_PC;
            else if (last_entry)                              state_in = ST_COPY_RD;
            else                                              state_in = ST_CARVE_RD;
         end
         ST_CARVE_PC: begin
            if (!pc_last)                   state_in = ST_CARVE_PC;
            else if (idx_ff == count_ff)    state_in = ST_COPY_RD;
            else                            state_in = ST_CARVE_RD;
         end
         ST_COPY_RD: begin
            if ((sidx_ff == npc_ff) || (count_ff == MAX_CNT)) state_in = ST_PRUNE_RDI;
            else                                              state_in = ST_COPY_WR;
         end
         ST_COPY_WR:  state_in = ST_COPY_RD;
         ST_PRUNE_RDI: begin
            if (idx_ff == count_ff) state_in = ST_RESP;
            else                    state_in = ST_PRUNE_LDI;
         end
         ST_PRUNE_LDI: state_in = ST_PRUNE_J;
         ST_PRUNE_J: begin
            if (j_done) state_in = ST_PRUNE_RDI;
            else        state_in = ST_PRUNE_CHK;
         end
         ST_PRUNE_CHK: begin
            if (contained) state_in = ST_PRUNE_RDI;
            else           state_in = ST_PRUNE_J;
         end
         ST_RESP:     state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Outputs: memory port controls and the result strobe.
   always_comb begin
      free_re     = 1'b0;
      free_raddr  = idx_ff[AW-1:0];
      free_we     = 1'b0;
      free_waddr  = keep_ff[AW-1:0];
      free_wdata  = free_rd_ff;
      spare_re    = 1'b0;
      spare_raddr = sidx_ff[SAW-1:0];
      spare_we    = 1'b0;
      spare_waddr = npc_ff[SAW-1:0];
      spare_wdata = pc_sel;
      case (state_ff)
         ST_CLEAR: begin
            free_we    = seed_ok;
            free_waddr = '0;
            free_wdata = {CB'(border_ff), CB'(border_ff),
                          CB'(aw_ff - 15'(border_ff)), CB'(ah_ff - 15'(border_ff))};
         end
         ST_SCAN_RD, ST_CARVE_RD: free_re = 1'b1;
         ST_CARVE_EV: free_we = !sflags.overlap;
         ST_CARVE_PC: spare_we = 1'b1;
         ST_COPY_RD: spare_re = (sidx_ff != npc_ff) && (count_ff != MAX_CNT);
         ST_COPY_WR: begin
            free_we    = 1'b1;
            free_waddr = count_ff[AW-1:0];
            free_wdata = spare_rd_ff;
         end
         ST_PRUNE_RDI: free_re = idx_ff != count_ff;
         ST_PRUNE_J: begin
            free_re    = !j_done;
            free_raddr = jn[AW-1:0];
            free_we    = j_done;
            free_wdata = cur_ff;
         end
         default: begin
         end
      endcase
   end

   assign busy      = state_ff != ST_IDLE;
   assign csr_ready = 1'b1;
   assign rsp_valid = state_ff == ST_RESP;
   assign rsp_status = status_ff;
   assign rsp_pos_x = ((status_ff == STAT_PLACED) || (status_ff == STAT_DROPPED)) ?
                      SPRITE_W'(ul_ff) : '0;
   assign rsp_pos_y = ((status_ff == STAT_PLACED) || (status_ff == STAT_DROPPED)) ?
                      SPRITE_W'(ut_ff) : '0;

   // Datapath register updates.
   always_comb begin
      count_in   = count_ff;
      idx_in     = idx_ff;
      keep_in    = keep_ff;
      j_in       = j_ff;
      npc_in     = npc_ff;
      sidx_in    = sidx_ff;
      fw_in      = fw_ff;
      fh_in      = fh_ff;
      found_in   = found_ff;
      dropped_in = dropped_ff;
      best_s_in  = best_s_ff;
      best_l_in  = best_l_ff;
      ul_in      = ul_ff;
      ut_in      = ut_ff;
      ur_in      = ur_ff;
      ub_in      = ub_ff;
      pvld_in    = pvld_ff;
      piece_in   = piece_ff;
      cur_in     = cur_ff;
      status_in  = status_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               fw_in      = FOOT_W'(req_sprite_width) + FOOT_W'({pad_ff, 1'b0});
               fh_in      = FOOT_W'(req_sprite_height) + FOOT_W'({pad_ff, 1'b0});
               idx_in     = '0;
               found_in   = 1'b0;
               dropped_in = 1'b0;
               status_in  = (req_action == ACT_CLEAR) ? STAT_CLEARED : STAT_NO_FIT;
            end
         end
         ST_CLEAR: count_in = seed_ok ? CW'(1) : '0;
         ST_SCAN_EV: begin
            if (better) begin
               found_in  = 1'b1;
               best_s_in = s_val;
               best_l_in = l_val;
               ul_in     = f_l;
               ut_in     = f_t;
               ur_in     = f_l + CB'(fw_ff);
               ub_in     = f_t + CB'(fh_ff);
            end
            idx_in = idx_inc;
            if (last_entry) begin
               idx_in  = '0;
               keep_in = '0;
               npc_in  = '0;
            end
         end
         ST_CARVE_EV: begin
            idx_in = idx_inc;
            if (!sflags.overlap) keep_in = keep_ff + CW'(1);
            pvld_in  = sflags.piece_vld;
            piece_in = spieces;
            if (last_entry && !(sflags.overlap && (sflags.piece_vld != 4'd0))) begin
               count_in = sflags.overlap ? keep_ff : keep_ff + CW'(1);
               sidx_in  = '0;
            end
         end
         ST_CARVE_PC: begin
            npc_in  = npc_ff + SW'(1);
            pvld_in = pvld_ff & ~pc_one;
            if (pc_last && (idx_ff == count_ff)) begin
               count_in = keep_ff;
               sidx_in  = '0;
            end
         end
         ST_COPY_RD: begin
            if ((sidx_ff == npc_ff) || (count_ff == MAX_CNT)) begin
               if (sidx_ff != npc_ff) dropped_in = 1'b1;
               idx_in  = '0;
               keep_in = '0;
            end
         end
         ST_COPY_WR: begin
            count_in = count_ff + CW'(1);
            sidx_in  = sidx_ff + SW'(1);
         end
         ST_PRUNE_RDI: begin
            if (idx_ff == count_ff) begin
               count_in  = keep_ff;
               status_in = dropped_ff ? STAT_DROPPED : STAT_PLACED;
            end
         end
         ST_PRUNE_LDI: begin
            cur_in = free_rd_ff;
            j_in   = '0;
         end
         ST_PRUNE_J: begin
            if (j_done) begin
               keep_in = keep_ff + CW'(1);
               idx_in  = idx_inc;
            end else begin
               j_in = jn + CW'(1);
            end
         end
         ST_PRUNE_CHK: begin
            if (contained) idx_in = idx_inc;
         end
         default: begin
         end
      endcase
   end

   // Control registers and configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         aw_ff     <= 15'd2048;
         ah_ff     <= 15'd2048;
         border_ff <= '0;
         pad_ff    <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ATLAS_WIDTH:  aw_ff     <= csr_wdata;
               CSR_ATLAS_HEIGHT: ah_ff     <= csr_wdata;
               CSR_BORDER:       border_ff <= csr_wdata[PAD_W-1:0];
               CSR_PADDING:      pad_ff    <= csr_wdata[PAD_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      keep_ff    <= keep_in;
      j_ff       <= j_in;
      npc_ff     <= npc_in;
      sidx_ff    <= sidx_in;
      fw_ff      <= fw_in;
      fh_ff      <= fh_in;
      found_ff   <= found_in;
      dropped_ff <= dropped_in;
      best_s_ff  <= best_s_in;
      best_l_ff  <= best_l_in;
      ul_ff      <= ul_in;
      ut_ff      <= ut_in;
      ur_ff      <= ur_in;
      ub_ff      <= ub_in;
      pvld_ff    <= pvld_in;
      piece_ff   <= piece_in;
      cur_ff     <= cur_in;
      status_ff  <= status_in;
   end

   // Free-rectangle store with a registered read port.
   always_ff @(posedge clock) begin
      if (free_we) free_mem[free_waddr] <= free_wdata;
      if (free_re) free_rd_ff <= free_mem[free_raddr];
   end

   // Piece buffer with a registered read port.
   always_ff @(posedge clock) begin
      if (spare_we) spare_mem[spare_waddr] <= spare_wdata;
      if (spare_re) spare_rd_ff <= spare_mem[spare_raddr];
   end

   // Checks.
   `MRP_ASSERT_NEXT(a_resp_single, rsp_valid, !rsp_valid)
   `MRP_ASSERT_NEXT(a_start_busy, start && !busy, busy)
   `MRP_ASSERT_IMPLY(a_count_max, 1'b1, count_ff <= MAX_CNT)
   `MRP_ASSERT_IMPLY(a_prune_keep, state_ff == ST_PRUNE_J, keep_ff <= idx_ff && idx_ff < count_ff)

endmodule

@@ sim/testbench.sv @@
`default_nettype none

// Checks the packer's results and follows its free-rectangle store.
class pack_scoreboard;
   localparam int DEPTH = mrp_pkg::MAX_FREE_DEF;
   localparam int unsigned CMASK = (1 << mrp_pkg::COORD_BITS_DEF) - 1;

   typedef struct {
      int unsigned l, t, r, b;
   } area_type;

   typedef struct {
      mrp_pkg::status_type status;
      logic [14:0]         x, y;
   } outcome_type;

   area_type    store[DEPTH];
   int unsigned fill;
   area_type    pieces[4*DEPTH];
   int unsigned atlas_w, atlas_h, margin, pad;
   outcome_type pending[$];
   int          errors;

   function new();
      atlas_w = 2048;
      atlas_h = 2048;
      margin  = 0;
      pad     = 0;
      fill    = 0;
      errors  = 0;
   endfunction

   function void write_reg(logic [1:0] idx, logic [14:0] val);
      case (idx)
         mrp_pkg::CSR_ATLAS_WIDTH:  atlas_w = val;
         mrp_pkg::CSR_ATLAS_HEIGHT: atlas_h = val;
         mrp_pkg::CSR_BORDER:       margin  = val[7:0];
         mrp_pkg::CSR_PADDING:      pad     = val[7:0];
         default: ;
      endcase
   endfunction

   function bit holds(area_type o, area_type i);
      return i.l >= o.l && i.t >= o.t && i.r <= o.r && i.b <= o.b;
   endfunction

   // Removes every rectangle contained in another, scanning in store order.
   function void prune();
      int unsigned i, j;
      bit gone;
      i = 0;
      while (i < fill) begin
         gone = 0;
         for (j = 0; j < fill; j++)
            if (i != j && holds(store[j], store[i])) begin
               gone = 1;
               break;
            end
         if (gone) begin
            for (j = i; j + 1 < fill; j++) store[j] = store[j+1];
            fill--;
         end else begin
            i++;
         end
      end
   endfunction

   // Splits the free rectangles around a placed footprint; returns 1 if pieces were lost.
   function bit split(area_type u);
      int unsigned n, keep, i;
      area_type f, p;
      bit lost;
      n = 0;
      keep = 0;
      lost = 0;
      for (i = 0; i < fill; i++) begin
         f = store[i];
         if (!(u.l < f.r && u.r > f.l && u.t < f.b && u.b > f.t)) begin
            store[keep++] = f;
            continue;
         end
         if (u.l > f.l) pieces[n++] = '{f.l, f.t, u.l, f.b};
         if (u.r < f.r) pieces[n++] = '{u.r, f.t, f.r, f.b};
         if (u.t > f.t) pieces[n++] = '{f.l, f.t, f.r, u.t};
         if (u.b < f.b) pieces[n++] = '{f.l, u.b, f.r, f.b};
      end
      fill = keep;
      for (i = 0; i < n; i++) begin
         if (fill < DEPTH) begin
            p = pieces[i];
            store[fill++] = '{p.l & CMASK, p.t & CMASK, p.r & CMASK, p.b & CMASK};
         end else begin
            lost = 1;
         end
      end
      prune();
      return lost;
   endfunction

   // Notes an accepted request and queues the result it must produce.
   function void note_request(logic act, logic [14:0] sw, logic [14:0] sh);
      outcome_type o;
      int unsigned fw, fh, best_s, best_l, rw, rh, dx, dy, s, lg, i;
      bit          found;
      area_type    u;
      o = '{mrp_pkg::STAT_CLEARED, 15'd0, 15'd0};
      if (act == mrp_pkg::ACT_CLEAR) begin
         fill = 0;
         if (atlas_w > margin * 2 && atlas_h > margin * 2) begin
            store[0] = '{margin & CMASK, margin & CMASK,
                         (atlas_w - margin) & CMASK, (atlas_h - margin) & CMASK};
            fill = 1;
         end
      end else begin
         fw = sw + pad * 2;
         fh = sh + pad * 2;
         best_s = '1;
         best_l = '1;
         found = 0;
         u = '{0, 0, 0, 0};
         for (i = 0; i < fill; i++) begin
            rw = store[i].r >= store[i].l ? store[i].r - store[i].l : 0;
            rh = store[i].b >= store[i].t ? store[i].b - store[i].t : 0;
            if (rw < fw || rh < fh) continue;
            dx = rw - fw;
            dy = rh - fh;
            s  = dx < dy ? dx : dy;
            lg = dx < dy ? dy : dx;
            if (s < best_s || (s == best_s && lg < best_l)) begin
               best_s = s;
               best_l = lg;
               u = '{store[i].l, store[i].t, store[i].l + fw, store[i].t + fh};
               found = 1;
            end
         end
         if (!found) begin
            o.status = mrp_pkg::STAT_NO_FIT;
         end else begin
            o.status = split(u) ? mrp_pkg::STAT_DROPPED : mrp_pkg::STAT_PLACED;
            o.x = u.l[14:0];
            o.y = u.t[14:0];
         end
      end
      pending = {pending, o};
   endfunction

   // Compares one result with the oldest queued one.
   function void check_result(logic [1:0] st, logic [14:0] x, logic [14:0] y);
      outcome_type o;
      if (pending.size() == 0) begin
         $error("result with nothing pending: status %0d x %0d y %0d", st, x, y);
         errors++;
         return;
      end
      o = pending.pop_front();
      if (st !== o.status) begin
         $error("status: expected %0d, got %0d", o.status, st);
         errors++;
      end
      if (x !== o.x) begin
         $error("pos_x: expected %0d, got %0d", o.x, x);
         errors++;
      end
      if (y !== o.y) begin
         $error("pos_y: expected %0d, got %0d", o.y, y);
         errors++;
      end
   endfunction
endclass

module testbench;
   import mrp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 100000000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic                 req_action = ACT_CLEAR;
   logic [SPRITE_W-1:0]  req_sprite_width = '0;
   logic [SPRITE_W-1:0]  req_sprite_height = '0;
   logic                 rsp_valid;
   logic [1:0]           rsp_status;
   logic [SPRITE_W-1:0]  rsp_pos_x;
   logic [SPRITE_W-1:0]  rsp_pos_y;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_ATLAS_WIDTH;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;

   pack_scoreboard board = new();
   int  cycles = 0;
   bit  steady = 0;
   int  cur_w = 2048, cur_h = 2048;

   maxrects_bssf_packer dut (.*);

   always #6 clock = ~clock;

   // Cycle counter that ends a hung run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("maxrects_bssf_packer verification failed");
         $finish;
      end
   end

   // Results cannot be held off, so each strobe is checked as it comes.
   always @(posedge clock) begin
      if (!reset && rsp_valid) board.check_result(rsp_status, rsp_pos_x, rsp_pos_y);
   end

   // Random pause between requests: mostly none or short, now and then long.
   task automatic pause();
      int r;
      r = $urandom_range(0, 19);
      if (steady || r < 10) return;
      start <= 1'b0;
      if (r < 18) repeat ($urandom_range(1, 3)) @(posedge clock);
      else repeat ($urandom_range(10, 80)) @(posedge clock);
   endtask

   // Presents one request and holds it until the packer takes it.
   task automatic send(logic act, int sw, int sh);
      start             <= 1'b1;
      req_action        <= act;
      req_sprite_width  <= sw[14:0];
      req_sprite_height <= sh[14:0];
      do @(posedge clock); while (busy);
      board.note_request(act, sw[14:0], sh[14:0]);
      pause();
   endtask

   // Lowers start and waits until the packer has gone quiet.
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (board.pending.size() != 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, int val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[14:0];
      do @(posedge clock); while (!csr_ready);
      board.write_reg(idx, val[14:0]);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic setup(int aw, int ah, int brd, int pd);
      drain();
      write_reg(CSR_ATLAS_WIDTH, aw);
      write_reg(CSR_ATLAS_HEIGHT, ah);
      write_reg(CSR_BORDER, brd);
      write_reg(CSR_PADDING, pd);
      cur_w = aw;
      cur_h = ah;
   endtask

   // A clear followed by a run of placements, most of them sized against the atlas.
   task automatic fill_run(int n);
      int sw, sh, r;
      send(ACT_CLEAR, $urandom, $urandom);
      for (int k = 0; k < n; k++) begin
         r = $urandom_range(0, 9);
         if (r == 0) begin
            sw = $urandom_range(0, 16384);
            sh = $urandom_range(0, 16384);
         end else begin
            sw = $urandom_range(0, cur_w / 3 + 1);
            sh = $urandom_range(0, cur_h / 3 + 1);
         end
         send(ACT_PLACE, sw, sh);
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Placement into an empty store, then the reset configuration.
      send(ACT_PLACE, 10, 10);
      send(ACT_CLEAR, 0, 0);
      send(ACT_PLACE, 2048, 2048);
      send(ACT_PLACE, 1, 1);
      send(ACT_CLEAR, 0, 0);
      send(ACT_PLACE, 0, 0);
      send(ACT_PLACE, 0, 100);
      send(ACT_PLACE, 100, 50);
      send(ACT_PLACE, 100, 50);
      send(ACT_PLACE, 2049, 1);

      // Pause until everything is back before the next request.
      drain();
      send(ACT_PLACE, 300, 700);

      // A 16384 by 16384 atlas and sprites as large as it.
      setup(16384, 16384, 0, 0);
      send(ACT_CLEAR, 0, 0);
      send(ACT_PLACE, 16384, 16384);
      send(ACT_PLACE, 1, 1);
      send(ACT_CLEAR, 0, 0);
      send(ACT_PLACE, 16383, 8191);

      // Border too wide to seed, the smallest atlas that seeds with it, then padding of 255.
      setup(510, 600, 255, 255);
      send(ACT_CLEAR, 0, 0);
      send(ACT_PLACE, 0, 0);
      setup(511, 511, 255, 0);
      send(ACT_CLEAR, 0, 0);
      send(ACT_PLACE, 1, 1);
      setup(1, 1, 0, 255);
      send(ACT_CLEAR, 0, 0);
      send(ACT_PLACE, 0, 0);
      setup(2000, 2000, 0, 255);
      send(ACT_CLEAR, 0, 0);
      send(ACT_PLACE, 0, 0);

      // Random phases over a range of configurations.
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: setup(2048, 2048, 0, 0);
            1: setup(16384, 16384, 255, 255);
            2: setup(64, 64, 3, 1);
            default: setup($urandom_range(1, 16384), $urandom_range(1, 16384),
                           $urandom_range(0, 255), $urandom_range(0, 40));
         endcase
         steady = (ph % 3 == 1);
         for (int run = 0; run < 2; run++) fill_run($urandom_range(4, 9));
      end
      steady = 0;

      drain();
      repeat (20) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("maxrects_bssf_packer verification clean");
      end else begin
         if (board.pending.size() != 0)
            $error("%0d results never arrived", board.pending.size());
         $display("maxrects_bssf_packer verification failed");
      end
      $finish;
   end
endmodule

`default_nettype wire

@@ files.f @@
+incdir+design
design/mrp_pkg.sv
design/mrp_split.sv
design/maxrects_bssf_packer.sv
sim/testbench.sv
